// File: rtl/core/elsf_pkg.sv
`default_nettype none

package elsf_pkg;

    // Frame geometry
    localparam int LINES       = 96;
    localparam int PAD_BYTES   = 1;
    localparam int SCAN_COUNT  = 24;
    localparam int HALF_BYTES  = 16;
    localparam int LINE_BYTES  = 32;
    localparam int MAX_RESULTS = 25;

    // Pad bytes emitted per line, capped at one burst
    localparam int PAD_EMIT = (PAD_BYTES > MAX_RESULTS - 1) ? (MAX_RESULTS - 1) : PAD_BYTES;

    localparam int POS_W  = $clog2(LINE_BYTES);
    localparam int LINE_W = 7;
    localparam int CNT_W  = $clog2(SCAN_COUNT);
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        MODE_NORMAL     = 2'd0,
        MODE_COMPENSATE = 2'd1,
        MODE_WHITE      = 2'd2,
        MODE_INVERT     = 2'd3
    } mode_t;

    // What the emitter has to do after the mapped byte
    typedef enum logic [1:0] {
        CMD_PLAIN = 2'd0,
        CMD_SCAN  = 2'd1,
        CMD_END   = 2'd2
    } cmd_kind_t;

    typedef enum logic [1:0] {
        BK_HEAD = 2'd0,
        BK_SCAN = 2'd1,
        BK_PAD  = 2'd2
    } back_state_t;

    typedef struct packed {
        logic [7:0]        data;
        cmd_kind_t         kind;
        logic [LINE_W-1:0] line;
        logic              last_line;
    } cmd_t;

    // Map the four 2-bit pixels of a byte through the stage mode
    function automatic logic [7:0] map_byte(input logic [7:0] b, input mode_t mode);
        logic [7:0] res;
        logic [1:0] px;
        logic [1:0] mp;
        res = '0;
        for (int i = 0; i < 4; i++)
        begin
            px = b[2*i +: 2];
            unique case (mode)
                MODE_NORMAL:     mp = px;
                MODE_COMPENSATE: mp = (px == 2'b11) ? 2'b10 : ((px == 2'b10) ? 2'b11 : 2'b00);
                MODE_WHITE:      mp = (px == 2'b10) ? 2'b10 : 2'b00;
                MODE_INVERT:     mp = (px == 2'b10) ? 2'b11 : 2'b00;
                default:         mp = px;
            endcase
            res[2*i +: 2] = mp;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/elsf_front.sv
`default_nettype none

module elsf_front
    import elsf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    input  wire logic [1:0] cfg_data,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       q_full,
    output logic            q_push,
    output cmd_t            q_data
);

    mode_t             mode_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic              last_line;
    logic              accept;

    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign q_push    = accept;
    assign last_line = (line_reg == LINE_W'(LINES - 1));

    // Classify the byte by its place in the line
    always_comb
    begin
        q_data.data      = map_byte(s_tdata, mode_reg);
        q_data.line      = line_reg;
        q_data.last_line = last_line;
        if (pos_reg == POS_W'(HALF_BYTES - 1))
            q_data.kind = CMD_SCAN;
        else if (pos_reg == POS_W'(LINE_BYTES - 1))
            q_data.kind = CMD_END;
        else
            q_data.kind = CMD_PLAIN;
    end

    // Advance byte position and line counters
    always_comb
    begin
        pos_next  = pos_reg;
        line_next = line_reg;
        if (accept)
        begin
            if (pos_reg == POS_W'(LINE_BYTES - 1))
            begin
                pos_next  = '0;
                line_next = last_line ? '0 : line_reg + LINE_W'(1);
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            pos_reg  <= '0;
            line_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
                mode_reg <= mode_t'(cfg_data);
            pos_reg  <= pos_next;
            line_reg <= line_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/elsf_queue.sv
`default_nettype none

module elsf_queue
    import elsf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_data,
    output logic      full,
    input  wire logic pop,
    output cmd_t      pop_data,
    output logic      empty
);

    cmd_t            entry_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_AW:0]   count_reg;

    assign full     = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // Track pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            if (push && !pop)
                count_reg <= count_reg + (Q_AW+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (Q_AW+1)'(1);
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/elsf_back.sv
`default_nettype none

module elsf_back
    import elsf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_empty,
    input  wire cmd_t       q_data,
    output logic            q_pop,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast,
    output logic            m_tuser
);

    back_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic              last_reg, last_next;
    logic              valid_reg, valid_next;
    logic [7:0]        data_reg, data_next;
    logic              ll_reg, ll_next;
    logic              fl_reg, fl_next;
    logic              out_free;
    logic [CNT_W-1:0]  scan_off;
    logic [7:0]        scan_val;
    logic              pad_fin;

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = ll_reg;
    assign m_tuser  = fl_reg;
    assign out_free = !valid_reg || m_tready;

    // Scan byte position and value for the held line
    assign scan_off = CNT_W'(SCAN_COUNT - 1) - CNT_W'(line_reg[LINE_W-1:2]);
    assign scan_val = 8'(8'h03 << {line_reg[1:0], 1'b0});
    assign pad_fin  = (cnt_reg == CNT_W'(PAD_EMIT - 1));

    // Emit head bytes, then scan or pad bursts
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        line_next  = line_reg;
        last_next  = last_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        ll_next    = ll_reg;
        fl_next    = fl_reg;
        q_pop      = 1'b0;
        if (out_free)
        begin
            valid_next = 1'b0;
            unique case (state_reg)
                BK_HEAD:
                begin
                    if (!q_empty)
                    begin
                        q_pop      = 1'b1;
                        valid_next = 1'b1;
                        data_next  = q_data.data;
                        ll_next    = 1'b0;
                        fl_next    = 1'b0;
                        line_next  = q_data.line;
                        last_next  = q_data.last_line;
                        cnt_next   = '0;
                        case (q_data.kind)
                            CMD_SCAN:
                            begin
                                state_next = BK_SCAN;
                            end
                            CMD_END:
                            begin
                                if (PAD_EMIT == 0)
                                begin
                                    ll_next = 1'b1;
                                    fl_next = q_data.last_line;
                                end
                                else
                                begin
                                    state_next = BK_PAD;
                                end
                            end
                            default:
                            begin
                                state_next = BK_HEAD;
                            end
                        endcase
                    end
                end
                BK_SCAN:
                begin
                    valid_next = 1'b1;
                    data_next  = (cnt_reg == scan_off) ? scan_val : 8'h00;
                    ll_next    = 1'b0;
                    fl_next    = 1'b0;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(SCAN_COUNT - 1))
                        state_next = BK_HEAD;
                end
                BK_PAD:
                begin
                    valid_next = 1'b1;
                    data_next  = 8'h00;
                    ll_next    = pad_fin;
                    fl_next    = pad_fin && last_reg;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    if (pad_fin)
                        state_next = BK_HEAD;
                end
                default:
                begin
                    state_next = BK_HEAD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_HEAD;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    // Hold payload of the output register and current line
    always_ff @(posedge clk)
    begin
        line_reg <= line_next;
        last_reg <= last_next;
        data_reg <= data_next;
        ll_reg   <= ll_next;
        fl_reg   <= fl_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/epaper_line_stream_formatter_unit.sv
// Panel scan line formatter.
// Input stream (s_*): frame bytes, 32 per line, four 2-bit pixels each.
// Output stream (m_*): panel line bytes in transmit order; m_tlast marks the
// final byte of each line, m_tuser the final byte of the last line of a frame.
// Configuration (cfg_*): stage mode, always ready; write only while idle.
// Each input transaction is mapped and queued in the same cycle; its first
// output byte is then popped from the queue into the output register.
// Frame bytes 15 and 31 expand into 25 and 1 + pad output bytes, so a line of
// 32 input bytes yields 56 + pad output bytes, one per cycle while commands
// are queued and the receiver accepts. Input runs at one byte per cycle until
// the four-entry command queue fills during a scan or pad burst.
// A stalled receiver holds the output register; the queue keeps accepting
// until full. Reset clears byte and line counters, queue and output valid,
// and returns the stage mode to normal.
`default_nettype none

module epaper_line_stream_formatter_unit
    import elsf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_data,      // [1:0] stage_mode
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,       // [7:0] pixel_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,       // [7:0] out_byte
    output logic            m_tlast,
    output logic            m_tuser        // [0] frame_last
);

    cmd_t push_data;
    cmd_t pop_data;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    assign cfg_ready = 1'b1;

    elsf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (push_data)
    );

    elsf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    elsf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (pop_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// File: rtl/core/elsf_checker.sv
`default_nettype none

module elsf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       cfg_valid,
    input wire logic       cfg_ready,
    input wire logic [1:0] cfg_data,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic [7:0] s_tdata,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic       m_tuser
);

    // Hold a stalled output transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
        else $error("output transaction changed while stalled");

    // Frame end only on a line end
    a_frame_on_line: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame_last without line_last");

    // No output once reset has been seen at an edge
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("output valid during reset");

    // Configuration port never stalls
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind epaper_line_stream_formatter_unit elsf_checker u_chk (.*);

`default_nettype wire

// File: bench/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import elsf_pkg::*;

    // Receiver hold-off, watchdog, settle and tail bounds in clock cycles, and the report limit
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_WAIT  = 4;
    localparam int TAIL_CYCLES  = 60;
    localparam int REPORT_LIMIT = 200;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC,
        RX_SPARSE
    } rx_style_t;

    // One byte of the panel line as it should leave the block
    typedef struct {
        logic [7:0] data;
        logic       line_end;
        logic       frame_end;
    } panel_byte_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_data  = 2'd0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    // Predicted formatter state
    mode_t       pred_mode = MODE_NORMAL;
    int          pred_pos  = 0;
    int          pred_line = 0;
    panel_byte_t panel_bytes_due[$];
    panel_byte_t due_byte;

    // Stimulus shaping
    int        burst_left   = 0;
    int        gap_max      = 0;
    int        burst_max    = 8;
    rx_style_t rx_style     = RX_ALWAYS;
    bit        hold_request = 1'b0;
    int        hold_left    = 0;
    int        rx_tick      = 0;

    int fail_count   = 0;
    int stall_cycles = 0;

    epaper_line_stream_formatter_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Map one 2-bit pixel through the stage mode
    function automatic logic [1:0] pixel_stage_map(input logic [1:0] px, input mode_t mode);
        logic [1:0] res;
        res = 2'b00;
        case (px)
            2'b11:
            begin
                if (mode == MODE_NORMAL)
                    res = 2'b11;
                else if (mode == MODE_COMPENSATE)
                    res = 2'b10;
            end
            2'b10:
            begin
                if (mode == MODE_COMPENSATE || mode == MODE_INVERT)
                    res = 2'b11;
                else
                    res = 2'b10;
            end
            2'b01:
            begin
                if (mode == MODE_NORMAL)
                    res = 2'b01;
            end
            default:
                res = 2'b00;
        endcase
        return res;
    endfunction

    function automatic void queue_panel_byte(input logic [7:0] data, input logic line_end,
                                             input logic frame_end);
        panel_byte_t pb;
        pb.data      = data;
        pb.line_end  = line_end;
        pb.frame_end = frame_end;
        panel_bytes_due.push_back(pb);
    endfunction

    // Work out the panel bytes caused by one accepted frame byte
    function automatic void predict_panel_bytes(input logic [7:0] value);
        logic [7:0] mapped;
        logic [7:0] scan_mark;
        int         line;
        int         scan_slot;
        int         pads;
        bit         on_last_line;
        mapped = '0;
        for (int i = 0; i < 4; i++)
            mapped[2*i +: 2] = pixel_stage_map(value[2*i +: 2], pred_mode);
        line         = pred_line % LINES;
        on_last_line = (line == LINES - 1);

        if (pred_pos == HALF_BYTES - 1)
        begin
            // Mapped byte, then the scan burst with one marked slot
            scan_slot = (SCAN_COUNT - 1) - (line / 4) % SCAN_COUNT;
            scan_mark = 8'(8'h03 << (2 * (line % 4)));
            queue_panel_byte(mapped, 1'b0, 1'b0);
            for (int k = 0; k < SCAN_COUNT; k++)
                queue_panel_byte((k == scan_slot) ? scan_mark : 8'h00, 1'b0, 1'b0);
        end
        else if (pred_pos == LINE_BYTES - 1)
        begin
            // Close the line, with padding if any
            pads = (PAD_BYTES > MAX_RESULTS - 1) ? MAX_RESULTS - 1 : PAD_BYTES;
            if (pads == 0)
                queue_panel_byte(mapped, 1'b1, on_last_line);
            else
            begin
                queue_panel_byte(mapped, 1'b0, 1'b0);
                for (int k = 0; k < pads; k++)
                    queue_panel_byte(8'h00, k == pads - 1, (k == pads - 1) && on_last_line);
            end
        end
        else
            queue_panel_byte(mapped, 1'b0, 1'b0);

        // Advance byte and line counters
        if (pred_pos >= LINE_BYTES - 1)
        begin
            pred_pos  = 0;
            pred_line = on_last_line ? 0 : line + 1;
        end
        else
        begin
            pred_pos  = pred_pos + 1;
            pred_line = line;
        end
    endfunction

    // Offer one frame byte in bursts with random gaps; returns at a falling edge
    task automatic send_frame_byte(input logic [7:0] value);
        int gap;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, burst_max);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        predict_panel_bytes(value);
        burst_left--;
        @(negedge clk);
    endtask

    // Drop valid and hold until every expected panel byte has left
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (panel_bytes_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_WAIT) @(negedge clk);
    endtask

    task automatic write_stage_mode(input mode_t mode);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        pred_mode = mode;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Reset mode first, then each stage mode on bytes that hold every pixel value
    task automatic test_directed_extremes();
        logic [7:0] seed_bytes[6];
        seed_bytes = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'hE4, 8'h1B};
        gap_max  = 0;
        rx_style = RX_ALWAYS;
        foreach (seed_bytes[i])
            send_frame_byte(seed_bytes[i]);
        // Run on to the scan burst
        while (pred_pos != 0 && pred_pos <= HALF_BYTES - 1)
            send_frame_byte(8'($urandom_range(0, 255)));
        for (int m = MODE_COMPENSATE; m <= MODE_INVERT; m++)
        begin
            write_stage_mode(mode_t'(m));
            send_frame_byte(8'hE4);
            send_frame_byte(8'h1B);
        end
    endtask

    // Random bytes across phases of stage mode, sender gaps and receiver stalls
    task automatic test_stage_modes_random();
        mode_t phase_modes[4];
        phase_modes = '{MODE_INVERT, MODE_NORMAL,
                        mode_t'($urandom_range(0, 3)), mode_t'($urandom_range(0, 3))};
        foreach (phase_modes[p])
        begin
            write_stage_mode(phase_modes[p]);
            rx_style  = rx_style_t'($urandom_range(RX_ALWAYS, RX_SPARSE));
            gap_max   = $urandom_range(0, 12);
            burst_max = $urandom_range(1, 16);
            repeat (16) send_frame_byte(8'($urandom_range(0, 255)));
        end
        wait_drained();
    endtask

    // Stall the receiver for a long stretch while the sender keeps offering
    task automatic test_backpressure_fill();
        gap_max      = 0;
        rx_style     = RX_RANDOM;
        hold_request = 1'b1;
        repeat (30) send_frame_byte(8'($urandom_range(0, 255)));
    endtask

    // Receiver ready pattern, with a long hold-off on request
    always @(negedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (hold_request)
        begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            case (rx_style)
                RX_ALWAYS:   m_tready <= 1'b1;
                RX_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: m_tready <= (rx_tick % 5 < 3);
                default:     m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Compare each output transaction with the oldest expected panel byte
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (panel_bytes_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display({"%0t: unexpected panel byte: expected none, ",
                              "got data %02h last %0b frame %0b"},
                             $time, m_tdata, m_tlast, m_tuser);
            end
            else
            begin
                due_byte = panel_bytes_due.pop_front();
                if (m_tdata !== due_byte.data || m_tlast !== due_byte.line_end ||
                    m_tuser !== due_byte.frame_end)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display({"%0t: panel byte: expected data %02h last %0b frame %0b, ",
                                  "got data %02h last %0b frame %0b"},
                                 $time, due_byte.data, due_byte.line_end,
                                 due_byte.frame_end, m_tdata, m_tlast, m_tuser);
                end
            end
        end
    end

    // Watchdog: end the run after a long stretch with no transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d panel bytes outstanding",
                     $time, panel_bytes_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        // Hold reset, then release it at a falling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_extremes();
        test_stage_modes_random();
        test_backpressure_fill();

        // Drain, then let the tail settle
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && panel_bytes_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
